[rtl/sfp_pkg.sv]
// Shared constants, codes and types of the serial frame parser.
`default_nettype none

package sfp_pkg;

  localparam int FrameBytes = 64;
  localparam int RawLimit   = FrameBytes - 5;
  localparam int LenLimit   = (RawLimit > 59) ? 59 : RawLimit;
  localparam int StoreDepth = 64;
  localparam int AddrW      = $clog2(StoreDepth);
  localparam int LenW       = 6;
  localparam int ByteW      = 8;
  localparam int CfgIdxW    = 1;

  localparam logic [ByteW-1:0] HdrFirstRst  = 8'hAA;
  localparam logic [ByteW-1:0] HdrSecondRst = 8'h55;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEADER_FIRST  = 1'b0,
    CFG_HEADER_SECOND = 1'b1
  } cfg_idx_e;

  // Frame handed from parser to readout on a good checksum.
  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] ftype;
    logic [LenW-1:0]  flen;
  } start_t;

  // Readout status seen by the parser.
  typedef struct packed {
    logic active;       // payload reads still to issue or in flight
    logic start_ready;  // readout idle and output register empty
  } rd_status_t;

  typedef struct packed {
    logic [ByteW-1:0] ftype;
    logic [LenW-1:0]  flen;
    logic             has_payload;
    logic [LenW-1:0]  idx;
    logic [ByteW-1:0] pbyte;
    logic             last;
  } item_t;

endpackage

`default_nettype wire

[rtl/sfp_ram.sv]
// Simple dual-port RAM, one write and one registered read port.
`default_nettype none

module sfp_ram #(
  parameter int Depth = 64,
  parameter int Width = 8,
  localparam int AW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/sfp_parser.sv]
// Header hunt, length check, payload write and checksum of incoming bytes.
`default_nettype none

module sfp_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sfp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [sfp_pkg::ByteW-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [sfp_pkg::ByteW-1:0]   in_byte_i,
  input  sfp_pkg::rd_status_t         rd_stat_i,
  output logic                        mem_we_o,
  output logic [sfp_pkg::AddrW-1:0]   mem_waddr_o,
  output logic [sfp_pkg::ByteW-1:0]   mem_wdata_o,
  output sfp_pkg::start_t             start_o
);

  import sfp_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_HDR2 = 3'd1,
    PH_TYPE = 3'd2,
    PH_LEN  = 3'd3,
    PH_DATA = 3'd4,
    PH_CKS  = 3'd5
  } phase_e;

  phase_e           phase_q;
  logic [ByteW-1:0] hdr1_q, hdr2_q;
  logic [ByteW-1:0] type_q;
  logic [LenW-1:0]  len_q;
  logic [AddrW-1:0] fill_q;
  logic [ByteW-1:0] sum_q;

  logic             fire;
  logic [ByteW-1:0] sum_add;
  logic [AddrW-1:0] fill_inc;

  // checksum byte waits while the previous frame still holds the output
  assign in_ready_o = !rd_stat_i.active && ((phase_q != PH_CKS) || rd_stat_i.start_ready);
  assign fire       = in_valid_i && in_ready_o;
  assign sum_add    = sum_q + in_byte_i;
  assign fill_inc   = fill_q + AddrW'(1);

  assign mem_we_o    = fire && (phase_q == PH_DATA);
  assign mem_waddr_o = fill_q;
  assign mem_wdata_o = in_byte_i;

  assign start_o.valid = fire && (phase_q == PH_CKS) && (in_byte_i == sum_q);
  assign start_o.ftype = type_q;
  assign start_o.flen  = len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      hdr1_q  <= HdrFirstRst;
      hdr2_q  <= HdrSecondRst;
      type_q  <= '0;
      len_q   <= '0;
      fill_q  <= '0;
      sum_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_HEADER_FIRST:  hdr1_q <= cfg_data_i;
          CFG_HEADER_SECOND: hdr2_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (fire) begin
        case (phase_q)
          PH_HDR2: begin
            if (in_byte_i == hdr2_q) begin
              sum_q   <= sum_add;
              phase_q <= PH_TYPE;
            end else if (in_byte_i == hdr1_q) begin
              sum_q <= in_byte_i;  // repeated first header restarts
            end else begin
              phase_q <= PH_HUNT;
              fill_q  <= '0;
              sum_q   <= '0;
            end
          end
          PH_TYPE: begin
            type_q  <= in_byte_i;
            sum_q   <= sum_add;
            phase_q <= PH_LEN;
          end
          PH_LEN: begin
            fill_q <= '0;
            if (in_byte_i == '0) begin
              sum_q   <= sum_add;
              len_q   <= '0;
              phase_q <= PH_CKS;
            end else if (in_byte_i > ByteW'(LenLimit)) begin
              phase_q <= PH_HUNT;
              sum_q   <= '0;
            end else begin
              sum_q   <= sum_add;
              len_q   <= in_byte_i[LenW-1:0];
              phase_q <= PH_DATA;
            end
          end
          PH_DATA: begin
            fill_q <= fill_inc;
            sum_q  <= sum_add;
            if (LenW'(fill_inc) >= len_q) begin
              phase_q <= PH_CKS;
            end
          end
          PH_CKS: begin
            phase_q <= PH_HUNT;
            fill_q  <= '0;
            sum_q   <= '0;
          end
          default: begin
            if (in_byte_i == hdr1_q) begin
              sum_q   <= in_byte_i;
              phase_q <= PH_HDR2;
            end else begin
              phase_q <= PH_HUNT;
            end
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

[rtl/sfp_readout.sv]
// Payload readout from the store into the output register.
`default_nettype none

module sfp_readout (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sfp_pkg::start_t           start_i,
  output sfp_pkg::rd_status_t       stat_o,
  output logic                      mem_re_o,
  output logic [sfp_pkg::AddrW-1:0] mem_raddr_o,
  input  logic [sfp_pkg::ByteW-1:0] mem_rdata_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output sfp_pkg::item_t            out_item_o
);

  import sfp_pkg::*;

  logic             active_q;
  logic             pend_q;
  logic             out_valid_q;
  logic [AddrW-1:0] addr_q;
  logic [LenW-1:0]  len_q;
  logic [ByteW-1:0] type_q;
  item_t            item_q;

  logic take, issue, last_rd;

  assign take    = out_valid_q && out_ready_i;
  // one read in flight; issued only when the output register will be free
  assign issue   = active_q && !pend_q && (!out_valid_q || take);
  assign last_rd = (LenW'(addr_q) + LenW'(1)) == len_q;

  assign mem_re_o    = issue;
  assign mem_raddr_o = addr_q;

  assign stat_o.active      = active_q;
  assign stat_o.start_ready = !active_q && !out_valid_q;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      addr_q      <= '0;
    end else begin
      if (take) begin
        out_valid_q <= 1'b0;
      end
      if (start_i.valid) begin
        if (start_i.flen == '0) begin
          out_valid_q <= 1'b1;
        end else begin
          active_q <= 1'b1;
          addr_q   <= '0;
        end
      end
      if (issue) begin
        pend_q <= 1'b1;
      end
      if (pend_q) begin
        pend_q      <= 1'b0;
        out_valid_q <= 1'b1;
        if (last_rd) begin
          active_q <= 1'b0;
        end else begin
          addr_q <= addr_q + AddrW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i.valid) begin
      type_q <= start_i.ftype;
      len_q  <= start_i.flen;
      if (start_i.flen == '0) begin
        item_q.ftype       <= start_i.ftype;
        item_q.flen        <= '0;
        item_q.has_payload <= 1'b0;
        item_q.idx         <= '0;
        item_q.pbyte       <= '0;
        item_q.last        <= 1'b1;
      end
    end
    if (pend_q) begin
      item_q.ftype       <= type_q;
      item_q.flen        <= len_q;
      item_q.has_payload <= 1'b1;
      item_q.idx         <= LenW'(addr_q);
      item_q.pbyte       <= mem_rdata_i;
      item_q.last        <= last_rd;
    end
  end

endmodule

`default_nettype wire

[rtl/serial_frame_parser_sum8.sv]
// Top level: byte-stream frame parser with 8-bit additive checksum.
// Input: one byte per cycle while parsing; stalled only during payload readout
//   and while a checksum byte waits for the previous frame's output to drain.
// The empty-frame marker is valid in the cycle after the checksum transaction; the
//   first payload item passes the readout start, the store read, then the output
//   register; each next store read waits until the output register is free.
// Reset (rst_ni, async, low): parser back to header hunt, headers 0xAA / 0x55,
//   output empty. The payload store is not cleared; entries are read only after
//   being written in the same frame.
`default_nettype none

module serial_frame_parser_sum8 (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration: 0 header_first, 1 header_second
  input  logic                        cfg_we_i,
  input  logic [sfp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [sfp_pkg::ByteW-1:0]   cfg_data_i,
  // received bytes
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [7:0] rx_byte
  // frame payload stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [31:0]                 m_axis_tdata,   // [7:0] frame_type, [13:8] frame_length,
                                                      // [19:14] byte_index, [27:20] payload_byte,
                                                      // [31:28] zero
  output logic                        m_axis_tuser,   // [0] has_payload
  output logic                        m_axis_tlast    // last
);

  import sfp_pkg::*;

  rd_status_t       rd_stat;
  start_t           start;
  item_t            item;
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [ByteW-1:0] mem_wdata, mem_rdata;

  // Header FSM, running sum and payload write side.
  sfp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .rd_stat_i   (rd_stat),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .start_o     (start)
  );

  // Payload store; writes during the data phase, reads only during readout,
  // so the two ports never touch the same entry in one cycle.
  sfp_ram #(
    .Depth (StoreDepth),
    .Width (ByteW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Walks the stored payload once the checksum matched.
  sfp_readout u_readout (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .stat_o      (rd_stat),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_item_o  (item)
  );

  assign m_axis_tdata = {4'b0000, item.pbyte, item.idx, item.flen, item.ftype};
  assign m_axis_tuser = item.has_payload;
  assign m_axis_tlast = item.last;

endmodule

`default_nettype wire

[rtl/sfp_checker.sv]
// Port-level checks of the frame parser, bound to the top level.
`default_nettype none

module sfp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // open run and the index its next transaction must carry
  logic       in_run_q;
  logic [5:0] next_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_run_q   <= 1'b0;
      next_idx_q <= '0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      in_run_q   <= m_axis_tuser && !m_axis_tlast;
      next_idx_q <= m_axis_tdata[19:14] + 6'd1;
    end
  end

  // stalled output transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("output changed while stalled");

  // empty-frame marker: single, last, zero length, index and byte
  a_empty_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && (m_axis_tdata[31:8] == 24'd0))
    else $error("malformed empty-frame marker");

  // payload index stays below length; last item sits at length - 1
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[19:14] < m_axis_tdata[13:8])
      && (m_axis_tlast == ((m_axis_tdata[19:14] + 6'd1) == m_axis_tdata[13:8])))
    else $error("payload index out of step with length");

  // a run starts at index zero and advances by one per transaction
  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (in_run_q ? (m_axis_tuser && (m_axis_tdata[19:14] == next_idx_q))
                                : (m_axis_tdata[19:14] == 6'd0)))
    else $error("payload index did not advance by one");

endmodule

bind serial_frame_parser_sum8 sfp_checker u_sfp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
